// ===== hdl/bac_pkg.sv =====
// shared constants, codes and types of the bond orientation autocorrelator
// no dependencies; compiled first
package bac_pkg;

  localparam int NUM_BINS_DEF    = 64;
  localparam int COORD_WIDTH_DEF = 32;

  // result field widths
  localparam int GAP_W   = 6;
  localparam int MEAN_W  = 18;
  localparam int COUNT_W = 24;
  localparam int SUM_W   = 42;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_MASK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEG_ORDER = 1'b1;
  localparam logic [2:0] DIM_MASK_RST  = 3'd7;
  localparam logic [1:0] LEG_ORDER_RST = 2'd2;
  localparam logic [1:0] LEG_P1        = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // status from the back end to the front end
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

// ===== hdl/bac_if.sv =====
// request and result channel interfaces with valid/ready handshake
// depends on bac_pkg
interface bac_in_if #(parameter int COORD_WIDTH = bac_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [bac_pkg::GAP_W-1:0]     gap_bin;
  logic signed [COORD_WIDTH-1:0] start_dx;
  logic signed [COORD_WIDTH-1:0] start_dy;
  logic signed [COORD_WIDTH-1:0] start_dz;
  logic signed [COORD_WIDTH-1:0] end_dx;
  logic signed [COORD_WIDTH-1:0] end_dy;
  logic signed [COORD_WIDTH-1:0] end_dz;

  modport source(output valid, mode, gap_bin, start_dx, start_dy, start_dz,
                 end_dx, end_dy, end_dz, input ready);
  modport sink(input valid, mode, gap_bin, start_dx, start_dy, start_dz,
               end_dx, end_dy, end_dz, output ready);
endinterface

interface bac_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bac_pkg::MEAN_W-1:0] bin_mean;
  logic [bac_pkg::COUNT_W-1:0]       bin_count;
  logic                              bin_empty;

  modport source(output valid, bin_mean, bin_count, bin_empty, input ready);
  modport sink(input valid, bin_mean, bin_count, bin_empty, output ready);
endinterface

// ===== hdl/bac_front.sv =====
// front end: config registers, request classification and a two-entry queue
// depends on bac_pkg and bac_if
module bac_front #(
  parameter int NUM_BINS    = bac_pkg::NUM_BINS_DEF,
  parameter int COORD_WIDTH = bac_pkg::COORD_WIDTH_DEF,
  parameter int AW          = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bac_in_if.sink                           in_ch,
  input  logic                             cfg_we,
  input  logic [bac_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  bac_pkg::back_stat_t              stat,
  output logic [2:0]                       dim_mask,
  output logic [1:0]                       leg_order,
  output logic                             q_valid,
  output bac_pkg::op_t                     q_op,
  output logic                             q_hit,
  output logic [AW-1:0]                    q_addr,
  output logic [5:0][COORD_WIDTH-1:0]      q_vec
);

  logic [2:0] dim_mask_r;
  logic [1:0] leg_order_r;

  bac_pkg::op_t                 op_q   [2];
  logic                         hit_q  [2];
  logic [AW-1:0]                addr_q [2];
  logic [5:0][COORD_WIDTH-1:0]  vec_q  [2];
  logic                         wr_r, rd_r;
  logic [1:0]                   cnt_r;

  logic [AW+bac_pkg::GAP_W-1:0] bin_ext;
  logic                         in_range;
  logic                         accept, push;
  bac_pkg::op_t                 in_op;

  // classify the incoming request
  assign bin_ext  = {{AW{1'b0}}, in_ch.gap_bin};
  assign in_range = bin_ext < (AW+bac_pkg::GAP_W)'(NUM_BINS);
  assign in_op    = bac_pkg::op_t'(in_ch.mode);
  assign in_ch.ready = (cnt_r != 2'd2) && !stat.clearing;
  assign accept   = in_ch.valid && in_ch.ready;
  // out-of-range accumulates are dropped here
  assign push     = accept && ((in_op == bac_pkg::OP_READ) || in_range);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_mask_r  <= bac_pkg::DIM_MASK_RST;
      leg_order_r <= bac_pkg::LEG_ORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bac_pkg::REG_DIM_MASK:  dim_mask_r  <= cfg_wdata[2:0];
        bac_pkg::REG_LEG_ORDER: leg_order_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (stat.pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, stat.pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_r]   <= in_op;
      hit_q[wr_r]  <= in_range;
      addr_q[wr_r] <= bin_ext[AW-1:0];
      vec_q[wr_r]  <= {in_ch.end_dz, in_ch.end_dy, in_ch.end_dx,
                       in_ch.start_dz, in_ch.start_dy, in_ch.start_dx};
    end
  end

  assign q_valid   = cnt_r != 2'd0;
  assign q_op      = op_q[rd_r];
  assign q_hit     = hit_q[rd_r];
  assign q_addr    = addr_q[rd_r];
  assign q_vec     = vec_q[rd_r];
  assign dim_mask  = dim_mask_r;
  assign leg_order = leg_order_r;

endmodule

// ===== hdl/bac_div.sv =====
// restoring divider, one quotient bit per cycle, 32 quotient bits
// no dependencies; quotient must fit 32 bits (num[63:32] < den)
module bac_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] rem_r, lo_r, quo_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;
  logic        take;

  assign trial = {rem_r, lo_r[31]};
  assign take  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[63:32];
      lo_r  <= num[31:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      lo_r  <= {lo_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], take};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/bac_sqrt.sv =====
// integer square root of a 64-bit value, two radicand bits per cycle
// no dependencies
module bac_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v_r, r_r, bit_r;
  logic        busy_r, done_r;
  logic [63:0] t;

  assign t = r_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one digit step
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      r_r   <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_r <= v_r - t;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

// ===== hdl/bac_back.sv =====
// back end: sequencer for vector normalisation, cosine, legendre term,
// bin memory read-modify-write and bin mean; depends on bac_pkg, bac_if,
// bac_div and bac_sqrt
module bac_back #(
  parameter int NUM_BINS    = bac_pkg::NUM_BINS_DEF,
  parameter int COORD_WIDTH = bac_pkg::COORD_WIDTH_DEF,
  parameter int AW          = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [2:0]                   dim_mask,
  input  logic [1:0]                   leg_order,
  input  logic                         q_valid,
  input  bac_pkg::op_t                 q_op,
  input  logic                         q_hit,
  input  logic [AW-1:0]                q_addr,
  input  logic [5:0][COORD_WIDTH-1:0]  q_vec,
  output bac_pkg::back_stat_t          stat,
  bac_out_if.source                    out_ch
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = bac_pkg::SUM_W;
  localparam int NW = bac_pkg::COUNT_W;
  localparam int MW = bac_pkg::MEAN_W;
  localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);
  localparam logic [31:0]   Q30_ONE  = 32'h4000_0000;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MEM1, ST_MEM2, ST_RD_DIV, ST_RD_WAIT, ST_RD_OUT,
    ST_LOAD, ST_SHIFT, ST_SUMSQ, ST_SQRT, ST_NDIV, ST_NWAIT, ST_DOT,
    ST_COS, ST_POLY, ST_P2SQ, ST_P2FIN, ST_WB
  } state_t;

  state_t state_r;

  // bin memory: sum in the upper bits, count in the lower
  logic [SW+NW-1:0] mem [NUM_BINS];
  logic [SW+NW-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SW+NW-1:0] mem_wdata;

  logic [AW-1:0]               clr_r;
  bac_pkg::op_t                op_r;
  logic                        hit_r;
  logic [AW-1:0]               addr_r;
  logic [5:0][CW-1:0]          vec_r;
  logic signed [SW-1:0]        sum_r;
  logic [NW-1:0]               cnt_r;
  logic                        vsel_r, phase_r;
  logic [1:0]                  step_r, ci_r;
  logic [2:0][CW-1:0]          mag_r;
  logic [2:0]                  neg_r;
  logic [2:0][31:0]            sq_r, v_r;
  logic [31:0]                 len_r;
  logic [1:0][2:0][31:0]       u_r;
  logic [63:0]                 prod_r, acc_r;
  logic signed [MW-1:0]        c_r, p_r;
  logic [MW-1:0]               stg_mean_r;
  logic [NW-1:0]               stg_cnt_r;
  logic                        stg_empty_r;
  logic                        out_valid_r;
  logic [MW-1:0]               out_mean_r;
  logic [NW-1:0]               out_cnt_r;
  logic                        out_empty_r;

  // mask decode
  logic [2:0]  msk;
  logic        oop;
  logic [1:0]  k;
  always_comb begin
    msk = (dim_mask == 3'd0) ? 3'd7 : dim_mask;
    oop = (msk == 3'd1) || (msk == 3'd2) || (msk == 3'd4);
    priority if (msk[0]) k = 2'd0;
    else if (msk[1])     k = 2'd1;
    else                 k = 2'd2;
  end

  // component magnitudes of the selected vector
  logic [2:0][CW-1:0] raw, ld_mag;
  logic [2:0]         ld_neg;
  logic [2:0][63:0]   m64;
  logic [2:0][31:0]   m32;
  logic               big;
  logic [31:0]        opa, opb, opk;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      raw[i]    = vsel_r ? vec_r[3+i] : vec_r[i];
      ld_neg[i] = raw[i][CW-1];
      ld_mag[i] = ld_neg[i] ? CW'(~raw[i] + 1'b1) : raw[i];
      if (!oop && !msk[i]) ld_mag[i] = '0;
      m64[i] = 64'(mag_r[i]);
      m32[i] = m64[i][31:0];
    end
    big = (m64[0] > 64'h8000_0000) || (m64[1] > 64'h8000_0000) ||
          (m64[2] > 64'h8000_0000);
    unique case (k)
      2'd0:    begin opk = m32[0]; opa = m32[1]; opb = m32[2]; end
      2'd1:    begin opk = m32[1]; opa = m32[2]; opb = m32[0]; end
      default: begin opk = m32[2]; opa = m32[0]; opb = m32[1]; end
    endcase
  end

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SUMSQ: if (step_r != 2'd3) begin
        mul_a = {1'b0, sq_r[step_r]};
        mul_b = {1'b0, sq_r[step_r]};
      end
      ST_DOT: if (step_r != 2'd3) begin
        mul_a = {u_r[0][step_r][31], u_r[0][step_r]};
        mul_b = {u_r[1][step_r][31], u_r[1][step_r]};
      end
      ST_P2SQ: begin
        mul_a = 33'(c_r);
        mul_b = 33'(c_r);
      end
      default: ;
    endcase
    mul_full = mul_a * mul_b;
  end

  // square root and divider units
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [63:0] div_num;
  logic [31:0] div_den, div_quo;
  logic        sneg;
  logic [SW-1:0] smag;

  assign sqrt_start = (state_r == ST_SUMSQ) && (step_r == 2'd3);
  assign sneg = sum_r[SW-1];
  assign smag = sneg ? SW'(-sum_r) : SW'(sum_r);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      ST_NDIV: begin
        div_start = 1'b1;
        div_num   = (64'(v_r[ci_r]) << 30) + 64'(len_r >> 1);
        div_den   = len_r;
      end
      ST_RD_DIV: begin
        div_start = 1'b1;
        div_num   = 64'(smag) + 64'(cnt_r >> 1);
        div_den   = 32'(cnt_r);
      end
      default: ;
    endcase
  end

  bac_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .val   (acc_r + prod_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  bac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // unit component: clamp and sign
  logic [31:0] qc, u_new;
  logic        u_sgn;
  assign qc    = (div_quo > Q30_ONE) ? Q30_ONE : div_quo;
  assign u_sgn = neg_r[ci_r] && !oop;
  assign u_new = u_sgn ? 32'(-qc) : qc;

  // cosine: round dot product from Q60 to Q16 and saturate
  logic        dneg;
  logic [63:0] dmag, drnd;
  logic [16:0] csat;
  logic signed [MW-1:0] c_new;
  always_comb begin
    dneg  = acc_r[63];
    dmag  = dneg ? 64'(-acc_r) : acc_r;
    drnd  = (dmag + (64'd1 << 43)) >> 44;
    csat  = (drnd > 64'd65536) ? 17'd65536 : drnd[16:0];
    c_new = dneg ? MW'(-{1'b0, csat}) : MW'({1'b0, csat});
  end

  // second order term (3c^2 - 1) / 2 in Q16
  logic [63:0] t64, tmag, trnd;
  logic        tneg;
  logic signed [MW-1:0] p2_new;
  always_comb begin
    t64    = prod_r + (prod_r << 1) - (64'd1 << 32);
    tneg   = t64[63];
    tmag   = tneg ? 64'(-t64) : t64;
    trnd   = (tmag + (64'd1 << 16)) >> 17;
    p2_new = tneg ? MW'(-trnd[MW-1:0]) : MW'(trnd[MW-1:0]);
  end

  logic [NW-1:0] cnt_now;
  assign cnt_now = hit_r ? rd_data_r[NW-1:0] : '0;

  // bin memory port
  always_comb begin
    mem_we    = (state_r == ST_CLEAR) || (state_r == ST_WB);
    mem_waddr = (state_r == ST_CLEAR) ? clr_r : addr_r;
    mem_wdata = (state_r == ST_CLEAR) ? '0 :
                {SW'(sum_r + SW'(p_r)), NW'(cnt_r + 1'b1)};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[addr_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      vsel_r      <= 1'b0;
      phase_r     <= 1'b0;
      step_r      <= '0;
      ci_r        <= '0;
      addr_r      <= '0;
    end else begin
      // result taken; a new one loads in ST_RD_OUT instead
      if (out_valid_r && out_ch.ready && (state_r != ST_RD_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_BIN) state_r <= ST_IDLE;
        end
        ST_IDLE: if (q_valid) begin
          op_r    <= q_op;
          hit_r   <= q_hit;
          addr_r  <= q_addr;
          vec_r   <= q_vec;
          state_r <= ST_MEM1;
        end
        ST_MEM1: state_r <= ST_MEM2;
        ST_MEM2: begin
          sum_r <= rd_data_r[SW+NW-1:NW];
          cnt_r <= cnt_now;
          if (op_r == bac_pkg::OP_READ) begin
            if (cnt_now == '0) begin
              stg_mean_r  <= '0;
              stg_cnt_r   <= '0;
              stg_empty_r <= 1'b1;
              state_r     <= ST_RD_OUT;
            end else begin
              state_r <= ST_RD_DIV;
            end
          end else if (cnt_now == bac_pkg::COUNT_MAX) begin
            state_r <= ST_IDLE;
          end else begin
            vsel_r  <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        ST_RD_DIV: state_r <= ST_RD_WAIT;
        ST_RD_WAIT: if (div_done) begin
          stg_mean_r  <= sneg ? MW'(-div_quo[MW-1:0]) : div_quo[MW-1:0];
          stg_cnt_r   <= cnt_r;
          stg_empty_r <= 1'b0;
          state_r     <= ST_RD_OUT;
        end
        ST_RD_OUT: if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
          out_mean_r  <= stg_mean_r;
          out_cnt_r   <= stg_cnt_r;
          out_empty_r <= stg_empty_r;
          state_r     <= ST_IDLE;
        end
        ST_LOAD: begin
          mag_r   <= ld_mag;
          neg_r   <= ld_neg;
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else begin
            if (oop) begin
              sq_r    <= {32'd0, opb, opa};
              phase_r <= 1'b0;
            end else begin
              sq_r    <= m32;
              v_r     <= m32;
              phase_r <= 1'b1;
            end
            step_r  <= '0;
            state_r <= ST_SUMSQ;
          end
        end
        ST_SUMSQ: begin
          acc_r  <= (step_r == 2'd0) ? 64'd0 : acc_r + prod_r;
          prod_r <= mul_full[63:0];
          step_r <= step_r + 1'b1;
          if (step_r == 2'd3) state_r <= ST_SQRT;
        end
        ST_SQRT: if (sqrt_done) begin
          if (!phase_r) begin
            sq_r    <= {32'd0, sqrt_root, opk};
            v_r     <= {32'd0, sqrt_root, opk};
            phase_r <= 1'b1;
            step_r  <= '0;
            state_r <= ST_SUMSQ;
          end else if (acc_r == 64'd0) begin
            // zero-length vector drops the sample
            state_r <= ST_IDLE;
          end else begin
            len_r   <= sqrt_root;
            ci_r    <= '0;
            state_r <= ST_NDIV;
          end
        end
        ST_NDIV: state_r <= ST_NWAIT;
        ST_NWAIT: if (div_done) begin
          u_r[vsel_r][ci_r] <= u_new;
          if (ci_r == 2'd2) begin
            if (!vsel_r) begin
              vsel_r  <= 1'b1;
              state_r <= ST_LOAD;
            end else begin
              step_r  <= '0;
              state_r <= ST_DOT;
            end
          end else begin
            ci_r    <= ci_r + 1'b1;
            state_r <= ST_NDIV;
          end
        end
        ST_DOT: begin
          acc_r  <= (step_r == 2'd0) ? 64'd0 : acc_r + prod_r;
          prod_r <= mul_full[63:0];
          step_r <= step_r + 1'b1;
          if (step_r == 2'd3) state_r <= ST_COS;
        end
        ST_COS: begin
          c_r     <= c_new;
          state_r <= ST_POLY;
        end
        ST_POLY: begin
          if (leg_order == bac_pkg::LEG_P1) begin
            p_r     <= c_r;
            state_r <= ST_WB;
          end else begin
            state_r <= ST_P2SQ;
          end
        end
        ST_P2SQ: begin
          prod_r  <= mul_full[63:0];
          state_r <= ST_P2FIN;
        end
        ST_P2FIN: begin
          p_r     <= p2_new;
          state_r <= ST_WB;
        end
        ST_WB: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign stat.clearing    = state_r == ST_CLEAR;
  assign stat.pop         = (state_r == ST_IDLE) && q_valid;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_mean  = out_mean_r;
  assign out_ch.bin_count = out_cnt_r;
  assign out_ch.bin_empty = out_empty_r;

endmodule

// ===== hdl/bond_orientation_autocorrelation.sv =====
// Bond orientation autocorrelation accumulator, Legendre P1/P2 per time-gap bin.
// Request channel in_ch: mode 0 adds one sample (start and end bond vectors,
// Q16.16) to bin gap_bin; mode 1 reads that bin. Only reads give a result on
// out_ch: bin_mean (Q1.16, rounded half away from zero), bin_count, bin_empty.
// Config port: cfg_we/cfg_idx/cfg_wdata; index 0 dim_mask, index 1
// legendre_order; write only while the block is idle.
// Requests enter a two-entry queue in the front end; the back end handles
// one at a time. An accumulate runs, per vector, one square root (two with
// a single axis selected, out of plane) and three divisions in the bit serial
// root and divider units, plus loading, dot product and memory update. A
// read takes one division.
// After reset the bin memory is cleared, one bin a cycle;
// in_ch.ready stays low meanwhile. A stalled result holds in the output
// register while the queue keeps taking requests; the back end waits only
// when a second read result is ready before the first has been taken.
// depends on bac_pkg, bac_if, bac_front, bac_back
module bond_orientation_autocorrelation #(
  parameter int NUM_BINS    = bac_pkg::NUM_BINS_DEF,
  parameter int COORD_WIDTH = bac_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bac_in_if.sink                         in_ch,
  bac_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bac_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  bac_pkg::back_stat_t          stat;
  logic [2:0]                   dim_mask;
  logic [1:0]                   leg_order;
  logic                         q_valid;
  bac_pkg::op_t                 q_op;
  logic                         q_hit;
  logic [AW-1:0]                q_addr;
  logic [5:0][COORD_WIDTH-1:0]  q_vec;

  // request classification and queue
  bac_front #(
    .NUM_BINS    (NUM_BINS),
    .COORD_WIDTH (COORD_WIDTH),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .dim_mask  (dim_mask),
    .leg_order (leg_order),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_hit     (q_hit),
    .q_addr    (q_addr),
    .q_vec     (q_vec)
  );

  // arithmetic sequencer and bin memory
  bac_back #(
    .NUM_BINS    (NUM_BINS),
    .COORD_WIDTH (COORD_WIDTH),
    .AW          (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dim_mask  (dim_mask),
    .leg_order (leg_order),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_hit     (q_hit),
    .q_addr    (q_addr),
    .q_vec     (q_vec),
    .stat      (stat),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/bac_chk.sv =====
// port-level checker for the autocorrelation block, bound to the top level
// depends on bac_pkg
module bac_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bac_pkg::MEAN_W-1:0] out_mean,
  input logic [bac_pkg::COUNT_W-1:0]       out_count,
  input logic                              out_empty
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // empty bin reports zero mean and zero count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> (out_mean == '0) && (out_count == '0))
    else $error("empty bin with nonzero fields");

  // nonempty bin has a count
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty |-> out_count != '0)
    else $error("nonempty bin with zero count");

  // mean stays within one
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mean <= 18'sd65536) && (out_mean >= -18'sd65536))
    else $error("bin mean out of range");

  // memory clear blocks requests right after reset
  a_clear_block: assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> !in_ready)
    else $error("request taken during memory clear");

endmodule

bind bond_orientation_autocorrelation bac_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mean  (out_ch.bin_mean),
  .out_count (out_ch.bin_count),
  .out_empty (out_ch.bin_empty)
);
